// ===== sv/gtc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtc_pkg: shared types and constants of the GRE tunnel classifier
// Field widths, protocol constants, action codes, controller/datapath
// command and status records and the outer IPv4 checksum helpers.
// ----------------------------------------------------------------------------
package gtc_pkg;

  localparam int TableEntriesDef = 64;

  localparam int KindW = 2;
  localparam int SlotW = 6;
  localparam int LenW  = 16;
  localparam int MacW  = 48;
  localparam int IpW   = 32;
  localparam int PortW = 16;
  localparam int HalfW = 16;
  localparam int ActW  = 2;
  localparam int SumW  = 19;

  localparam int CWordW = MacW + IpW;
  localparam int TWordW = PortW + IpW + IpW;

  localparam logic [KindW-1:0] KindPkt      = 2'd0;
  localparam logic [KindW-1:0] KindClientWr = 2'd1;
  localparam logic [KindW-1:0] KindTunnelWr = 2'd2;

  localparam logic [15:0]     EtypeIpv4  = 16'h0800;
  localparam logic [3:0]      IpVersion  = 4'd4;
  localparam logic [3:0]      IpIhl      = 4'd5;
  localparam logic [7:0]      IpProtoGre = 8'd47;
  localparam logic [IpW-1:0]  GreTebWord = 32'h0000_6558;
  localparam logic [7:0]      OuterTtl   = 8'd64;
  localparam logic [15:0]     IpVerTos   = 16'h4500;
  localparam logic [LenW-1:0] OuterExtra = 16'd24;
  localparam logic [LenW-1:0] MinFrame   = 16'd14;
  localparam logic [LenW-1:0] MinDecap   = 16'd38;
  localparam logic [LenW-1:0] MinInner   = 16'd52;
  localparam logic [MacW-1:0] BcastMac   = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [ActW-1:0] {
    ACT_PASS  = 2'd0,
    ACT_ENCAP = 2'd1,
    ACT_DECAP = 2'd2,
    ACT_WDONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KEY_SRC_MAC    = 2'd0,
    KEY_DST_MAC    = 2'd1,
    KEY_CLIENT_TUN = 2'd2,
    KEY_PEER_IP    = 2'd3
  } key_sel_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [SlotW-1:0] slot;
    logic             entry_valid;
    logic [LenW-1:0]  frame_length;
    logic [MacW-1:0]  mac_address;
    logic [MacW-1:0]  inner_dst_mac;
    logic [15:0]      ether_type;
    logic [15:0]      ip_ver_ihl_proto;
    logic [IpW-1:0]   gre_header;
    logic [IpW-1:0]   tunnel_ip;
    logic [IpW-1:0]   local_ip;
    logic [PortW-1:0] out_port;
  } item_t;

  typedef struct packed {
    action_t          action;
    logic [PortW-1:0] egress_port;
    logic [IpW-1:0]   outer_src_ip;
    logic [IpW-1:0]   outer_dst_ip;
    logic [LenW-1:0]  ip_total_length;
    logic [HalfW-1:0] ip_header_checksum;
  } result_t;

  typedef struct packed {
    logic     scan_start;
    key_sel_t key_sel;
    logic     wr_table;
    logic     calc_sum;
    logic     load;
    action_t  res_act;
  } cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             short_frame;
    logic             decap_ok;
    logic             inner_ok;
    logic             bcast;
    logic             scan_done;
    logic             scan_hit;
    logic             out_free;
  } sts_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic logic [SumW-1:0] hdr_sum(input logic [LenW-1:0] tot,
                                              input logic [IpW-1:0] src,
                                              input logic [IpW-1:0] dst);
    return SumW'(IpVerTos) + SumW'(tot) + SumW'({OuterTtl, IpProtoGre})
         + SumW'(src[31:16]) + SumW'(src[15:0])
         + SumW'(dst[31:16]) + SumW'(dst[15:0]);
  endfunction

  function automatic logic [HalfW-1:0] csum_fold(input logic [SumW-1:0] s);
    logic [HalfW:0]   s1;
    logic [HalfW-1:0] s2;
    s1 = (HalfW+1)'(s[15:0]) + (HalfW+1)'(s[SumW-1:16]);
    s2 = s1[HalfW-1:0] + HalfW'(s1[HalfW]);
    return ~s2;
  endfunction

endpackage

// ===== sv/gtc_if.sv =====
// ----------------------------------------------------------------------------
// gtc_if: item and result channels of the GRE tunnel classifier
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface gtc_in_if;
  logic                      valid;
  logic                      ready;
  logic [gtc_pkg::KindW-1:0] kind;
  logic [gtc_pkg::SlotW-1:0] slot;
  logic                      entry_valid;
  logic [gtc_pkg::LenW-1:0]  frame_length;
  logic [gtc_pkg::MacW-1:0]  mac_address;
  logic [gtc_pkg::MacW-1:0]  inner_dst_mac;
  logic [15:0]               ether_type;
  logic [15:0]               ip_ver_ihl_proto;
  logic [gtc_pkg::IpW-1:0]   gre_header;
  logic [gtc_pkg::IpW-1:0]   tunnel_ip;
  logic [gtc_pkg::IpW-1:0]   local_ip;
  logic [gtc_pkg::PortW-1:0] out_port;

  modport source (output valid, kind, slot, entry_valid, frame_length, mac_address,
                  inner_dst_mac, ether_type, ip_ver_ihl_proto, gre_header, tunnel_ip,
                  local_ip, out_port, input ready);
  modport sink (input valid, kind, slot, entry_valid, frame_length, mac_address,
                inner_dst_mac, ether_type, ip_ver_ihl_proto, gre_header, tunnel_ip,
                local_ip, out_port, output ready);
endinterface

interface gtc_out_if;
  logic                      valid;
  logic                      ready;
  logic [gtc_pkg::ActW-1:0]  action;
  logic [gtc_pkg::PortW-1:0] egress_port;
  logic [gtc_pkg::IpW-1:0]   outer_src_ip;
  logic [gtc_pkg::IpW-1:0]   outer_dst_ip;
  logic [gtc_pkg::LenW-1:0]  ip_total_length;
  logic [gtc_pkg::HalfW-1:0] ip_header_checksum;

  modport source (output valid, action, egress_port, outer_src_ip, outer_dst_ip,
                  ip_total_length, ip_header_checksum, input ready);
  modport sink (input valid, action, egress_port, outer_src_ip, outer_dst_ip,
                ip_total_length, ip_header_checksum, output ready);
endinterface

// ===== sv/gtc_ram.sv =====
// ----------------------------------------------------------------------------
// gtc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [gtc_pkg::addr_w(DEPTH)-1:0]     waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [gtc_pkg::addr_w(DEPTH)-1:0]     raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/gtc_datapath.sv =====
// ----------------------------------------------------------------------------
// gtc_datapath: tables, search engine and result register
// Holds the item, the client and tunnel tables with their valid bits, a
// linear search engine over one table, the checksum stage and the result.
// ----------------------------------------------------------------------------
module gtc_datapath #(
  parameter int TABLE_ENTRIES = gtc_pkg::TableEntriesDef
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_load,
  input  gtc_pkg::item_t   item_in,
  input  gtc_pkg::cmd_t    cmd,
  output gtc_pkg::sts_t    sts,
  input  logic             res_ready,
  output logic             res_valid,
  output gtc_pkg::result_t res_data
);

  localparam int AW = gtc_pkg::addr_w(TABLE_ENTRIES);
  localparam logic [AW-1:0] LastAddr = AW'(TABLE_ENTRIES - 1);

  gtc_pkg::item_t   item;
  gtc_pkg::result_t res_next;

  logic [TABLE_ENTRIES-1:0] cvalid;
  logic [TABLE_ENTRIES-1:0] tvalid;

  logic [AW-1:0] scan_addr;
  logic [AW-1:0] cmp_addr;
  logic [AW-1:0] waddr;
  logic          issue_en;
  logic          cmp_live;
  logic          scan_tun;
  logic          scan_tun_next;
  logic [gtc_pkg::MacW-1:0] key;
  logic [gtc_pkg::MacW-1:0] key_next;

  logic [gtc_pkg::CWordW-1:0] crd;
  logic [gtc_pkg::TWordW-1:0] trd;
  logic [gtc_pkg::TWordW-1:0] tword;
  logic [gtc_pkg::IpW-1:0]    client_tun;
  logic [gtc_pkg::LenW-1:0]   tot;
  logic [gtc_pkg::LenW-1:0]   tot_next;
  logic [gtc_pkg::SumW-1:0]   hsum;

  logic slot_ok;
  logic cwe;
  logic twe;
  logic match;
  logic last;

  assign slot_ok = int'(item.slot) < TABLE_ENTRIES;
  assign waddr   = AW'(item.slot);
  assign cwe = cmd.wr_table && slot_ok && item.entry_valid
               && (item.kind == gtc_pkg::KindClientWr);
  assign twe = cmd.wr_table && slot_ok && item.entry_valid
               && (item.kind == gtc_pkg::KindTunnelWr);

  gtc_ram #(.WIDTH(gtc_pkg::CWordW), .DEPTH(TABLE_ENTRIES)) u_client_ram (
    .clk   (clk),
    .we    (cwe),
    .waddr (waddr),
    .wdata ({item.mac_address, item.tunnel_ip}),
    .raddr (scan_addr),
    .rdata (crd)
  );

  gtc_ram #(.WIDTH(gtc_pkg::TWordW), .DEPTH(TABLE_ENTRIES)) u_tunnel_ram (
    .clk   (clk),
    .we    (twe),
    .waddr (waddr),
    .wdata ({item.out_port, item.local_ip, item.tunnel_ip}),
    .raddr (scan_addr),
    .rdata (trd)
  );

  always_comb begin
    case (cmd.key_sel)
      gtc_pkg::KEY_SRC_MAC:    key_next = item.mac_address;
      gtc_pkg::KEY_DST_MAC:    key_next = item.inner_dst_mac;
      gtc_pkg::KEY_CLIENT_TUN: key_next = gtc_pkg::MacW'(client_tun);
      gtc_pkg::KEY_PEER_IP:    key_next = gtc_pkg::MacW'(item.tunnel_ip);
      default:                 key_next = '0;
    endcase
    scan_tun_next = (cmd.key_sel == gtc_pkg::KEY_CLIENT_TUN)
                    || (cmd.key_sel == gtc_pkg::KEY_PEER_IP);
  end

  always_comb begin
    if (scan_tun) begin
      match = tvalid[cmp_addr] && (trd[gtc_pkg::IpW-1:0] == key[gtc_pkg::IpW-1:0]);
    end else begin
      match = cvalid[cmp_addr] && (crd[gtc_pkg::CWordW-1:gtc_pkg::IpW] == key);
    end
    last = (cmp_addr == LastAddr);
  end

  assign tot_next = item.frame_length + gtc_pkg::OuterExtra;

  always_comb begin
    sts.kind        = item.kind;
    sts.short_frame = item.frame_length < gtc_pkg::MinFrame;
    sts.decap_ok    = (item.ether_type == gtc_pkg::EtypeIpv4)
                      && (item.frame_length >= gtc_pkg::MinDecap)
                      && (item.ip_ver_ihl_proto[15:12] == gtc_pkg::IpVersion)
                      && (item.ip_ver_ihl_proto[11:8] == gtc_pkg::IpIhl)
                      && (item.ip_ver_ihl_proto[7:0] == gtc_pkg::IpProtoGre)
                      && (item.gre_header == gtc_pkg::GreTebWord);
    sts.inner_ok    = item.frame_length >= gtc_pkg::MinInner;
    sts.bcast       = item.inner_dst_mac == gtc_pkg::BcastMac;
    sts.scan_done   = cmp_live && (match || last);
    sts.scan_hit    = cmp_live && match;
    sts.out_free    = !res_valid || res_ready;
  end

  always_comb begin
    res_next        = '0;
    res_next.action = cmd.res_act;
    if (cmd.res_act == gtc_pkg::ACT_ENCAP) begin
      res_next.egress_port        = tword[gtc_pkg::TWordW-1:2*gtc_pkg::IpW];
      res_next.outer_src_ip       = tword[2*gtc_pkg::IpW-1:gtc_pkg::IpW];
      res_next.outer_dst_ip       = tword[gtc_pkg::IpW-1:0];
      res_next.ip_total_length    = tot;
      res_next.ip_header_checksum = gtc_pkg::csum_fold(hsum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_en  <= 1'b0;
      cmp_live  <= 1'b0;
      cvalid    <= '0;
      tvalid    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        issue_en <= 1'b1;
        cmp_live <= 1'b0;
      end else if (sts.scan_done) begin
        issue_en <= 1'b0;
        cmp_live <= 1'b0;
      end else begin
        cmp_live <= issue_en;
        if (issue_en && (scan_addr == LastAddr)) begin
          issue_en <= 1'b0;
        end
      end
      if (cmd.wr_table && slot_ok) begin
        if (item.kind == gtc_pkg::KindClientWr) begin
          cvalid[waddr] <= item.entry_valid;
        end else if (item.kind == gtc_pkg::KindTunnelWr) begin
          tvalid[waddr] <= item.entry_valid;
        end
      end
      if (cmd.load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      item <= item_in;
    end
    if (cmd.scan_start) begin
      scan_addr <= '0;
      key       <= key_next;
      scan_tun  <= scan_tun_next;
    end else if (issue_en && (scan_addr != LastAddr)) begin
      scan_addr <= scan_addr + 1'b1;
    end
    cmp_addr <= scan_addr;
    if (sts.scan_hit) begin
      if (scan_tun) begin
        tword <= trd;
      end else begin
        client_tun <= crd[gtc_pkg::IpW-1:0];
      end
    end
    if (cmd.calc_sum) begin
      tot  <= tot_next;
      hsum <= gtc_pkg::hdr_sum(tot_next, tword[2*gtc_pkg::IpW-1:gtc_pkg::IpW],
                               tword[gtc_pkg::IpW-1:0]);
    end
    if (cmd.load) begin
      res_data <= res_next;
    end
  end

endmodule

// ===== sv/gtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gtc_ctrl: sequencing controller of the GRE tunnel classifier
// Takes one item at a time, orders the table searches and picks the action.
// ----------------------------------------------------------------------------
module gtc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output gtc_pkg::cmd_t cmd,
  input  gtc_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CSCAN,
    S_TSCAN_ENC,
    S_TSCAN_DEC,
    S_DSCAN,
    S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd   <= '0;
    end else begin
      cmd.scan_start <= 1'b0;
      cmd.wr_table   <= 1'b0;
      cmd.calc_sum   <= 1'b0;
      cmd.load       <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (sts.kind inside {gtc_pkg::KindClientWr, gtc_pkg::KindTunnelWr}) begin
            cmd.wr_table <= 1'b1;
            cmd.res_act  <= gtc_pkg::ACT_WDONE;
            state        <= S_FINISH;
          end else if ((sts.kind != gtc_pkg::KindPkt) || sts.short_frame) begin
            cmd.res_act <= gtc_pkg::ACT_PASS;
            state       <= S_FINISH;
          end else begin
            cmd.scan_start <= 1'b1;
            cmd.key_sel    <= gtc_pkg::KEY_SRC_MAC;
            state          <= S_CSCAN;
          end
        end
        S_CSCAN: begin
          if (sts.scan_done) begin
            if (sts.scan_hit) begin
              cmd.scan_start <= 1'b1;
              cmd.key_sel    <= gtc_pkg::KEY_CLIENT_TUN;
              state          <= S_TSCAN_ENC;
            end else if (sts.decap_ok) begin
              cmd.scan_start <= 1'b1;
              cmd.key_sel    <= gtc_pkg::KEY_PEER_IP;
              state          <= S_TSCAN_DEC;
            end else begin
              cmd.res_act <= gtc_pkg::ACT_PASS;
              state       <= S_FINISH;
            end
          end
        end
        S_TSCAN_ENC: begin
          if (sts.scan_done) begin
            if (sts.scan_hit) begin
              cmd.calc_sum <= 1'b1;
              cmd.res_act  <= gtc_pkg::ACT_ENCAP;
            end else begin
              cmd.res_act <= gtc_pkg::ACT_PASS;
            end
            state <= S_FINISH;
          end
        end
        S_TSCAN_DEC: begin
          if (sts.scan_done) begin
            if (!sts.scan_hit || !sts.inner_ok) begin
              cmd.res_act <= gtc_pkg::ACT_PASS;
              state       <= S_FINISH;
            end else if (sts.bcast) begin
              cmd.res_act <= gtc_pkg::ACT_DECAP;
              state       <= S_FINISH;
            end else begin
              cmd.scan_start <= 1'b1;
              cmd.key_sel    <= gtc_pkg::KEY_DST_MAC;
              state          <= S_DSCAN;
            end
          end
        end
        S_DSCAN: begin
          if (sts.scan_done) begin
            cmd.res_act <= sts.scan_hit ? gtc_pkg::ACT_DECAP : gtc_pkg::ACT_PASS;
            state       <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (sts.out_free) begin
            cmd.load <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/gre_tunnel_classifier_top.sv =====
// ----------------------------------------------------------------------------
// gre_tunnel_classifier_top: GRE/TEB tunnel classifier
// Items arrive on pkt: a packet header or a write to the client or tunnel
// table. Each item yields exactly one result transaction on res: pass,
// encapsulate (outer IPv4 source, destination, total length, checksum and
// egress port), decapsulate, or write done.
// One item is in work at a time. A table write goes from dispatch straight
// to finish. A packet walks the tables one slot per cycle through the
// registered RAM read port, and a packet needs up to three searches
// (source MAC, tunnel peer, inner destination MAC); encapsulation needs two
// searches, short or unmatched frames finish earlier. The next item is
// taken at the edge that loads the result into the output register.
// Reset clears all valid bits of both tables at once; there is no clearing
// sweep. Table data is only read under a set valid bit.
// When res stalls, the result waits in the output register; a finished item
// holds until that register is free, and pkt.ready stays low meanwhile.
// ----------------------------------------------------------------------------
module gre_tunnel_classifier_top #(
  parameter int TABLE_ENTRIES = gtc_pkg::TableEntriesDef
) (
  input logic       clk,
  input logic       rst,
  gtc_in_if.sink    pkt,
  gtc_out_if.source res
);

  gtc_pkg::item_t   item_in;
  gtc_pkg::result_t res_data;
  gtc_pkg::cmd_t    cmd;
  gtc_pkg::sts_t    sts;
  logic             in_ready;
  logic             res_valid;

  assign item_in = '{
    kind:             pkt.kind,
    slot:             pkt.slot,
    entry_valid:      pkt.entry_valid,
    frame_length:     pkt.frame_length,
    mac_address:      pkt.mac_address,
    inner_dst_mac:    pkt.inner_dst_mac,
    ether_type:       pkt.ether_type,
    ip_ver_ihl_proto: pkt.ip_ver_ihl_proto,
    gre_header:       pkt.gre_header,
    tunnel_ip:        pkt.tunnel_ip,
    local_ip:         pkt.local_ip,
    out_port:         pkt.out_port
  };

  assign pkt.ready = in_ready;

  gtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pkt.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  gtc_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item_load (pkt.valid && in_ready),
    .item_in   (item_in),
    .cmd       (cmd),
    .sts       (sts),
    .res_ready (res.ready),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  assign res.valid              = res_valid;
  assign res.action             = res_data.action;
  assign res.egress_port        = res_data.egress_port;
  assign res.outer_src_ip       = res_data.outer_src_ip;
  assign res.outer_dst_ip       = res_data.outer_dst_ip;
  assign res.ip_total_length    = res_data.ip_total_length;
  assign res.ip_header_checksum = res_data.ip_header_checksum;

endmodule

// ===== sv/gtc_checker.sv =====
// ----------------------------------------------------------------------------
// gtc_checker: port-level checks of the GRE tunnel classifier
// Watches the item and result channels of the top level.
// ----------------------------------------------------------------------------
module gtc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [gtc_pkg::ActW-1:0]  action,
  input logic [gtc_pkg::PortW-1:0] egress_port,
  input logic [gtc_pkg::IpW-1:0]   outer_src_ip,
  input logic [gtc_pkg::IpW-1:0]   outer_dst_ip,
  input logic [gtc_pkg::LenW-1:0]  ip_total_length,
  input logic [gtc_pkg::HalfW-1:0] ip_header_checksum
);

  // one item in work: no transaction right behind another
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item taken while previous item still in work");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(action) && $stable(egress_port)
      && $stable(outer_src_ip) && $stable(outer_dst_ip) && $stable(ip_total_length)
      && $stable(ip_header_checksum)))
    else $error("stalled result changed");

  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (action != gtc_pkg::ACT_ENCAP)) |->
      (egress_port == '0 && outer_src_ip == '0 && outer_dst_ip == '0
       && ip_total_length == '0 && ip_header_checksum == '0))
    else $error("non-encap result carries header fields");

  a_encap_csum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (action == gtc_pkg::ACT_ENCAP)) |->
      (ip_header_checksum == gtc_pkg::csum_fold(
        gtc_pkg::hdr_sum(ip_total_length, outer_src_ip, outer_dst_ip))))
    else $error("outer header checksum mismatch");

endmodule

bind gre_tunnel_classifier_top gtc_checker u_gtc_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (pkt.valid),
  .in_ready           (pkt.ready),
  .out_valid          (res.valid),
  .out_ready          (res.ready),
  .action             (res.action),
  .egress_port        (res.egress_port),
  .outer_src_ip       (res.outer_src_ip),
  .outer_dst_ip       (res.outer_dst_ip),
  .ip_total_length    (res.ip_total_length),
  .ip_header_checksum (res.ip_header_checksum)
);
